/* hw/rtl/hpe_pkg.sv */
// Package for the Hermite polynomial evaluator: widths, status codes,
// word types and the pipeline stage record. No dependencies.
`timescale 1ns / 1ps

package hpe_pkg;

    localparam int DEGREE_W        = 5;
    localparam int X_W             = 16;
    localparam int POLY_W          = 64;
    localparam int MAX_DEGREE_DEF  = 20;
    localparam int X_FRAC_BITS_DEF = 12;

    // recurrence datapath
    localparam int R_W        = 128;
    localparam int HUGE_BITS  = 108;
    localparam int NUM_LIMBS  = 4;
    localparam int LIMB_W     = 27;
    localparam int TOP_LIMB_W = HUGE_BITS + 1 - LIMB_W * (NUM_LIMBS - 1);
    localparam int PP_W       = TOP_LIMB_W + X_W;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_OVERFLOW    = 2'd1,
        STATUS_UNSUPPORTED = 2'd2
    } status_t;

    typedef struct packed {
        logic [DEGREE_W-1:0]   degree;
        logic signed [X_W-1:0] x_value;
    } item_t;

    typedef struct packed {
        logic signed [POLY_W-1:0] poly_value;
        status_t                  status;
    } result_t;

    typedef struct packed {
        logic [DEGREE_W-1:0]   degree;
        logic signed [X_W-1:0] x_value;
        logic                  sticky;
        logic signed [R_W-1:0] prev;
        logic signed [R_W-1:0] cur;
    } hpe_stage_t;

endpackage

/* hw/rtl/hermite_polynomial_eval.sv */
// Hermite polynomial evaluator H_n(x), n up to MAX_DEGREE, x signed fixed point.
// Pipeline stages from accepted word to result:
// one input stage, a multiply stage and an accumulate stage per recurrence step,
// one output stage. Throughput one word per cycle; a stalled result holds all.
// Reset clears the valid bits only. Depends on hpe_pkg.
`timescale 1ns / 1ps

module hermite_polynomial_eval #(
    parameter int MAX_DEGREE  = hpe_pkg::MAX_DEGREE_DEF,
    parameter int X_FRAC_BITS = hpe_pkg::X_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  hpe_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_ready,
    output hpe_pkg::result_t result
);

    import hpe_pkg::*;

    localparam int NUM_STAGES = MAX_DEGREE;
    localparam logic signed [R_W-1:0] ONE_R      = R_W'(1) <<< X_FRAC_BITS;
    localparam logic signed [R_W-1:0] HALF_R     = R_W'(1) <<< (X_FRAC_BITS - 1);
    localparam logic signed [R_W-1:0] HUGE_R     = R_W'(1) <<< HUGE_BITS;
    localparam logic signed [R_W-1:0] NEG_HUGE_R = -HUGE_R;
    localparam logic [POLY_W-1:0] POLY_MAX = {1'b0, {(POLY_W-1){1'b1}}};
    localparam logic [POLY_W-1:0] POLY_MIN = {1'b1, {(POLY_W-1){1'b0}}};

    hpe_stage_t st_reg       [NUM_STAGES];
    logic       st_valid_reg [NUM_STAGES];
    hpe_stage_t first_next;
    hpe_stage_t last;
    result_t    result_reg;
    result_t    result_next;
    logic       result_valid_reg;
    logic       advance;
    logic       fits;

    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = advance;

    // input stage
    always_comb
    begin
        first_next.degree  = item.degree;
        first_next.x_value = item.x_value;
        first_next.sticky  = 1'b0;
        first_next.prev    = ONE_R;
        if (item.degree == '0)
        begin
            first_next.cur = ONE_R;
        end
        else
        begin
            first_next.cur = R_W'($signed(item.x_value)) <<< 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            st_valid_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            st_reg[0] <= first_next;
        end
    end

    // recurrence steps
    for (genvar k = 1; k < NUM_STAGES; k++)
    begin : g_step
        logic                              mu_valid_reg;
        logic                              mu_active_reg;
        hpe_stage_t                        mu_st_reg;
        logic [NUM_LIMBS-1:0][PP_W-1:0]    mu_pp_reg;
        logic [NUM_LIMBS-1:0][PP_W-1:0]    mu_pp_next;
        logic                              mu_active_next;
        logic signed [R_W-1:0]             prod;
        logic signed [R_W-1:0]             scaled;
        logic signed [R_W-1:0]             nxt;
        hpe_stage_t                        cmb_next;

        always_comb
        begin
            for (int i = 0; i < NUM_LIMBS - 1; i++)
            begin
                mu_pp_next[i] = PP_W'($signed({1'b0, st_reg[k-1].cur[i*LIMB_W +: LIMB_W]})
                                      * $signed(st_reg[k-1].x_value));
            end
            mu_pp_next[NUM_LIMBS-1] =
                PP_W'($signed(st_reg[k-1].cur[(NUM_LIMBS-1)*LIMB_W +: TOP_LIMB_W])
                      * $signed(st_reg[k-1].x_value));
            mu_active_next = !st_reg[k-1].sticky && (st_reg[k-1].degree > DEGREE_W'(k));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mu_valid_reg    <= 1'b0;
                st_valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                mu_valid_reg    <= st_valid_reg[k-1];
                st_valid_reg[k] <= mu_valid_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                mu_st_reg     <= st_reg[k-1];
                mu_pp_reg     <= mu_pp_next;
                mu_active_reg <= mu_active_next;
                st_reg[k]     <= cmb_next;
            end
        end

        always_comb
        begin
            prod = '0;
            for (int i = 0; i < NUM_LIMBS; i++)
            begin
                prod = prod + (R_W'($signed(mu_pp_reg[i])) <<< (LIMB_W * i));
            end
            scaled = ((prod <<< 1) + HALF_R) >>> X_FRAC_BITS;
            nxt    = scaled - mu_st_reg.prev * R_W'(2 * k);
            cmb_next = mu_st_reg;
            if (mu_active_reg)
            begin
                cmb_next.prev   = mu_st_reg.cur;
                cmb_next.cur    = nxt;
                cmb_next.sticky = (nxt >= HUGE_R) || (nxt <= NEG_HUGE_R);
            end
        end
    end

    // output stage: saturate and flag
    assign last = st_reg[NUM_STAGES-1];
    assign fits = (&last.cur[R_W-1:POLY_W-1]) || (~|last.cur[R_W-1:POLY_W-1]);

    always_comb
    begin
        if (last.degree > DEGREE_W'(MAX_DEGREE))
        begin
            result_next.poly_value = '0;
            result_next.status     = STATUS_UNSUPPORTED;
        end
        else if (last.sticky)
        begin
            result_next.poly_value = (last.x_value[X_W-1] && last.degree[0]) ? POLY_MIN
                                                                              : POLY_MAX;
            result_next.status     = STATUS_OVERFLOW;
        end
        else if (!fits)
        begin
            result_next.poly_value = last.cur[R_W-1] ? POLY_MIN : POLY_MAX;
            result_next.status     = STATUS_OVERFLOW;
        end
        else
        begin
            result_next.poly_value = last.cur[POLY_W-1:0];
            result_next.status     = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= st_valid_reg[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && st_valid_reg[NUM_STAGES-1])
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_sticky_saturates : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st_valid_reg[NUM_STAGES-1] && last.sticky
         && (last.degree <= DEGREE_W'(MAX_DEGREE)))
        |=> (result.status == STATUS_OVERFLOW))
        else $error("huge intermediate did not saturate");

    a_degree_zero_one : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st_valid_reg[NUM_STAGES-1] && (last.degree == '0))
        |=> (result.poly_value == POLY_W'(ONE_R)) && (result.status == STATUS_OK))
        else $error("degree zero did not give one");

    a_valid_travels : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !st_valid_reg[NUM_STAGES-1]) |=> !result_valid)
        else $error("result shown without a word in the last stage");

endmodule

/* sim/testbench.sv */
// Self-checking bench for hermite_polynomial_eval: directed and random words, random
// stalls on both channels, results checked against an in-bench recurrence predictor.
// Depends on hpe_pkg and the hermite_polynomial_eval RTL.
`timescale 1ns / 1ps

module testbench;

    import hpe_pkg::*;

    localparam int MAX_DEG = MAX_DEGREE_DEF;
    localparam int FRAC    = X_FRAC_BITS_DEF;
    localparam logic signed [127:0] ONE_Q    = 128'sd1 <<< FRAC;
    localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (FRAC - 1);
    localparam logic signed [127:0] FIT_MAX  = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] FIT_MIN  = -FIT_MAX - 128'sd1;
    localparam logic signed [63:0]  SAT_POS  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]  SAT_NEG  = 64'sh8000_0000_0000_0000;
    localparam int NUM_RANDOM = 1300;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        item_t   src;
        result_t want;
    } pending_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    item_t    word_q[$];
    pending_t hermite_expect_q[$];
    pending_t head;
    logic     word_sent = 1'b0;
    logic     hold_on;
    int       send_gap = 0;
    int       recv_stall = 0;
    int       sent_count = 0;
    int       results_seen = 0;
    int       errors = 0;

    hermite_polynomial_eval uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic result_t compute_hermite(item_t w);
        logic signed [127:0] r_prev;
        logic signed [127:0] r_cur;
        logic signed [127:0] r_next;
        logic signed [127:0] two_x;
        logic signed [127:0] mag;
        logic                huge;
        int                  k;
        result_t             r;
        huge = 1'b0;
        r.poly_value = '0;
        r.status = STATUS_OK;
        if (w.degree > MAX_DEG)
        begin
            r.status = STATUS_UNSUPPORTED;
            return r;
        end
        two_x = {{112{w.x_value[15]}}, w.x_value};
        two_x = two_x <<< 1;
        r_prev = ONE_Q;
        r_cur = (w.degree == 0) ? ONE_Q : two_x;
        for (k = 1; k < w.degree && !huge; k++)
        begin
            r_next = (r_cur * two_x + HALF_LSB) >>> FRAC;
            r_next = r_next - r_prev * (2 * k);
            r_prev = r_cur;
            r_cur = r_next;
            mag = r_cur[127] ? -r_cur : r_cur;
            huge = (mag[127:108] != '0);
        end
        if (huge)
        begin
            r.status = STATUS_OVERFLOW;
            r.poly_value = (w.x_value[15] && w.degree[0]) ? SAT_NEG : SAT_POS;
        end
        else if (r_cur > FIT_MAX || r_cur < FIT_MIN)
        begin
            r.status = STATUS_OVERFLOW;
            r.poly_value = r_cur[127] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            r.poly_value = r_cur[63:0];
        end
        return r;
    endfunction

    function automatic int pick_gap(bit quiet);
        int sel;
        sel = $urandom_range(0, 99);
        if (quiet || sel < 55)
            return 0;
        else if (sel < 88)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic add_word(int n, int x);
        item_t w;
        w.degree = n[4:0];
        w.x_value = x[15:0];
        word_q.push_back(w);
    endtask

    task automatic report_mismatch(string msg);
        if (errors < 100)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // send side: hold the word until taken, then idle for a random gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || word_sent)
            begin
                if (send_gap > 0)
                begin
                    item_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (word_q.size() > 0)
                begin
                    item <= word_q.pop_front();
                    item_valid <= 1'b1;
                    send_gap <= pick_gap((sent_count % 300) < 80);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // receive side: random stalls, plus one long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_on)
            begin
                result_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                result_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                recv_stall <= pick_gap(((results_seen + 150) % 300) < 80);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_sent <= item_valid && item_ready;
            if (item_valid && item_ready)
            begin
                hermite_expect_q.push_back('{src: item, want: compute_hermite(item)});
                sent_count <= sent_count + 1;
            end
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (hermite_expect_q.size() == 0)
                begin
                    report_mismatch("result with no word pending");
                end
                else
                begin
                    head = hermite_expect_q.pop_front();
                    if (result.poly_value !== head.want.poly_value)
                        report_mismatch($sformatf("n=%0d x=%0d poly_value got %0d want %0d",
                            head.src.degree, head.src.x_value, result.poly_value,
                            head.want.poly_value));
                    if (result.status !== head.want.status)
                        report_mismatch($sformatf("n=%0d x=%0d status got %0d want %0d",
                            head.src.degree, head.src.x_value, result.status,
                            head.want.status));
                end
            end
        end
    end

    initial
    begin
        hold_on = 1'b0;
        wait (results_seen >= 150);
        @(negedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("hermite_polynomial_eval: mismatch");
        $finish;
    end

    initial
    begin
        int sel;
        int n;
        int x;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;

        add_word(0, 0);
        add_word(0, -32768);
        add_word(1, 32767);
        add_word(1, -32768);
        add_word(2, 4096);
        add_word(3, -4096);
        add_word(5, 1);
        add_word(7, -1);
        add_word(10, 6144);
        add_word(20, 0);
        add_word(20, 32767);
        add_word(19, -32768);
        add_word(20, -32768);
        add_word(21, 100);
        add_word(31, -1);
        add_word(25, 32767);
        add_word(4, 2048);
        add_word(12, 12000);
        add_word(15, -9000);
        add_word(16, 3);
        add_word(11, -12345);
        add_word(8, 20000);
        add_word(18, -20000);
        add_word(13, 16384);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, MAX_DEG)
                                             : $urandom_range(MAX_DEG + 1, 31);
            sel = $urandom_range(0, 99);
            if (sel < 50)
                x = $urandom();
            else if (sel < 80)
                x = $urandom_range(0, 24576) - 12288;
            else
                x = $urandom_range(0, 127) - 64;
            add_word(n, x);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (word_q.size() != 0 || item_valid)
            @(posedge clk);
        while (hermite_expect_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("hermite_polynomial_eval: match");
        else
            $display("hermite_polynomial_eval: mismatch");
        $finish;
    end

endmodule

/* hermite_polynomial_eval.f */
hw/rtl/hpe_pkg.sv
hw/rtl/hermite_polynomial_eval.sv
sim/testbench.sv
